// File: design/assert_macros.svh
// Assertion macro used by the sequencer top level.
// Depends on nothing; included where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`endif

// File: design/apcs_pkg.sv
// Package for the ATA PIO command sequencer: phases, actions and constants.
// Used by the sequencer top level only; depends on nothing.
`timescale 1ns / 1ps
package apcs_pkg;
    typedef enum logic [3:0] {
        PH_IDLE, PH_SETTLE, PH_SEL_POLL, PH_PROBE_POLL, PH_DRAIN,
        PH_IDLE_WAIT, PH_DRQ_WAIT, PH_READ_DATA, PH_WRITE_DATA, PH_FLUSH_WAIT
    } phase_t;

    localparam logic [2:0] ACT_REGW = 3'd0;
    localparam logic [2:0] ACT_STAT = 3'd1;
    localparam logic [2:0] ACT_ALT  = 3'd2;
    localparam logic [2:0] ACT_DATR = 3'd3;
    localparam logic [2:0] ACT_DATW = 3'd4;
    localparam logic [2:0] ACT_HOST = 3'd5;
    localparam logic [2:0] ACT_DONE = 3'd6;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_RESP  = 2'd1;
    localparam logic [1:0] OP_HOST  = 2'd2;

    localparam logic [1:0] CMD_PROBE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;

    localparam int SECTOR_WORDS_DEF = 256;
    localparam int QUIET_SAMPLE_LIMIT_DEF = 16;
    localparam logic [31:0] TIMEOUT_RESET = 32'd4000000;

    localparam logic [9:0] BASE_PRI = 10'h1F0;
    localparam logic [9:0] BASE_SEC = 10'h170;
    localparam logic [9:0] ALT_OFS = 10'h206;
    localparam logic [7:0] SEL_MASTER = 8'hE0;
    localparam logic [7:0] SEL_SLAVE = 8'hF0;
    localparam logic [7:0] CMD_IDENTIFY = 8'hEC;
    localparam logic [7:0] CMD_RD_SECT = 8'h20;
    localparam logic [7:0] CMD_WR_SECT = 8'h30;
    localparam logic [7:0] ST_FLOAT = 8'hFF;
    localparam logic [7:0] ST_BSY = 8'h80;
    localparam logic [7:0] ST_DF = 8'h20;
    localparam logic [7:0] ST_DRQ = 8'h08;
    localparam logic [7:0] ST_ERR = 8'h01;

    localparam int MAX_RES = 8;
    typedef struct packed {
        logic [2:0] action;
        logic [9:0] addr;
        logic [15:0] value;
        logic outcome;
    } res_t;
endpackage

// File: design/ata_pio_command_sequencer.sv
// ATA PIO command sequencer top level: input register, phase logic, result queue.
// Depends on apcs_pkg and assert_macros.svh.
//
// channel   direction  tdata fields (low bit up)
// s_axis    in         operation, command, drive, lba, read_value, write_word
// m_axis    out        action, bus_address, bus_value, outcome (tlast = last)
// cfg       in         timeout_limit
//
// Each accepted word is registered, then decoded combinationally into up to seven
// results that enter a sixteen-entry queue; results leave one per cycle while
// m_axis_tready is high, the first once the queue has been written. A new word
// is taken in every cycle in which the queue, counting the burst of the registered
// word, holds no more than eight results. Reset leaves the phase idle and the queue
// empty. A stall on m_axis fills the queue and then holds s_axis_tready low.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ata_pio_command_sequencer
    import apcs_pkg::*;
#(
    parameter int SECTOR_WORDS = SECTOR_WORDS_DEF,
    parameter int QUIET_SAMPLE_LIMIT = QUIET_SAMPLE_LIMIT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // operation[1:0], command[3:2], drive[6:4], lba[34:7], read_value[50:35],
    // write_word[66:51], zero fill
    input  logic [71:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // action[2:0], bus_address[12:3], bus_value[28:13], outcome[29], zero fill
    output logic [31:0] m_axis_tdata,
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);
    localparam int WIW = $clog2(SECTOR_WORDS + 1);
    localparam logic [WIW-1:0] SW = WIW'(SECTOR_WORDS);

    logic [31:0] timeout_reg;
    phase_t phase_reg, phase_next;
    logic [31:0] budget_reg, budget_next;
    logic [2:0] settle_reg, settle_next;
    logic [WIW-1:0] widx_reg, widx_next;
    logic [1:0] cmd_reg, cmd_next, drv_reg, drv_next;
    logic [27:0] lba_reg, lba_next;

    logic in_v_reg;
    logic [71:0] in_reg;

    res_t q_reg [MAX_RES*2];
    logic q_last_reg [MAX_RES*2];
    logic [3:0] rd_reg, wr_reg;
    logic [4:0] cnt_reg;

    res_t r [MAX_RES];
    logic [3:0] nres;

    logic [1:0] op, icmd;
    logic [2:0] idrv;
    logic [7:0] s;
    logic [15:0] v;
    logic [9:0] b;
    logic [7:0] selb;

    assign op = in_reg[1:0];
    assign icmd = in_reg[3:2];
    assign idrv = in_reg[6:4];
    assign v = in_reg[50:35];
    assign s = v[7:0];
    assign b = drv_reg[1] ? BASE_SEC : BASE_PRI;
    assign selb = drv_reg[0] ? SEL_SLAVE : SEL_MASTER;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        logic [9:0] nb;
        logic [7:0] ns;
        logic [31:0] bm1;
        for (int i = 0; i < MAX_RES; i++) r[i] = '0;
        nres = '0;
        phase_next = phase_reg;
        budget_next = budget_reg;
        settle_next = settle_reg;
        widx_next = widx_reg;
        cmd_next = cmd_reg;
        drv_next = drv_reg;
        lba_next = lba_reg;
        nb = idrv[1] ? BASE_SEC : BASE_PRI;
        ns = idrv[0] ? SEL_SLAVE : SEL_MASTER;
        bm1 = budget_reg - 32'd1;
        if (in_v_reg) begin
            if (op == OP_START && phase_reg == PH_IDLE) begin
                if (idrv > 3'd3 || icmd == 2'd3) begin
                    r[0] = '{ACT_DONE, 10'd0, 16'd0, 1'b1}; nres = 4'd1;
                end else begin
                    cmd_next = icmd; drv_next = idrv[1:0]; lba_next = in_reg[34:7];
                    r[0] = '{ACT_REGW, nb + 10'd6, {8'd0, ns}, 1'b0};
                    r[1] = '{ACT_ALT, nb + ALT_OFS, 16'd0, 1'b0};
                    nres = 4'd2; settle_next = 3'd1; phase_next = PH_SETTLE;
                end
            end else if (op == OP_HOST && phase_reg == PH_WRITE_DATA) begin
                r[0] = '{ACT_DATW, b, in_reg[66:51], 1'b0};
                nres = 4'd1;
                widx_next = widx_reg + 1'b1;
                if (widx_next >= SW) begin
                    budget_next = timeout_reg;
                    r[1] = '{ACT_STAT, b + 10'd7, 16'd0, 1'b0}; nres = 4'd2;
                    phase_next = PH_FLUSH_WAIT;
                end
            end else if (op == OP_RESP && phase_reg != PH_IDLE
                         && phase_reg != PH_WRITE_DATA) begin
                unique case (phase_reg)
                    PH_SETTLE:
                        if (settle_reg < 3'd4) begin
                            settle_next = settle_reg + 3'd1;
                            r[0] = '{ACT_ALT, b + ALT_OFS, 16'd0, 1'b0}; nres = 4'd1;
                        end else begin
                            budget_next = timeout_reg;
                            r[0] = '{ACT_STAT, b + 10'd7, 16'd0, 1'b0}; nres = 4'd1;
                            phase_next = PH_SEL_POLL;
                        end
                    PH_SEL_POLL:
                        if ((s & ST_BSY) != 0) begin
                            if (s == ST_FLOAT || budget_reg == 0) begin
                                r[0] = '{ACT_DONE, 10'd0, 16'd0, 1'b1}; nres = 4'd1;
                                phase_next = PH_IDLE;
                            end else begin
                                budget_next = bm1;
                                r[0] = '{ACT_STAT, b + 10'd7, 16'd0, 1'b0}; nres = 4'd1;
                            end
                        end else begin
                            budget_next = timeout_reg;
                            if (cmd_reg == CMD_PROBE) begin
                                r[0] = '{ACT_REGW, b + 10'd2, 16'd0, 1'b0};
                                r[1] = '{ACT_REGW, b + 10'd3, 16'd0, 1'b0};
                                r[2] = '{ACT_REGW, b + 10'd4, 16'd0, 1'b0};
                                r[3] = '{ACT_REGW, b + 10'd5, 16'd0, 1'b0};
                                r[4] = '{ACT_REGW, b + 10'd7, {8'd0, CMD_IDENTIFY}, 1'b0};
                                r[5] = '{ACT_STAT, b + 10'd7, 16'd0, 1'b0};
                                nres = 4'd6; phase_next = PH_PROBE_POLL;
                            end else begin
                                r[0] = '{ACT_REGW, b + 10'd2, 16'd1, 1'b0};
                                r[1] = '{ACT_REGW, b + 10'd3, {8'd0, lba_reg[7:0]}, 1'b0};
                                r[2] = '{ACT_REGW, b + 10'd4, {8'd0, lba_reg[15:8]}, 1'b0};
                                r[3] = '{ACT_REGW, b + 10'd5, {8'd0, lba_reg[23:16]}, 1'b0};
                                r[4] = '{ACT_REGW, b + 10'd6,
                                         {8'd0, selb | {4'd0, lba_reg[27:24]}}, 1'b0};
                                r[5] = '{ACT_REGW, b + 10'd7, {8'd0,
                                         cmd_reg == CMD_READ ? CMD_RD_SECT : CMD_WR_SECT},
                                         1'b0};
                                r[6] = '{ACT_STAT, b + 10'd7, 16'd0, 1'b0};
                                nres = 4'd7; phase_next = PH_IDLE_WAIT;
                            end
                            if (s == ST_FLOAT) begin
                                r[0] = '{ACT_DONE, 10'd0, 16'd0, 1'b1}; nres = 4'd1;
                                phase_next = PH_IDLE; budget_next = budget_reg;
                            end
                        end
                    PH_PROBE_POLL:
                        if (s == ST_FLOAT || s == 8'd0) begin
                            r[0] = '{ACT_DONE, 10'd0, 16'd0, 1'b1}; nres = 4'd1;
                            phase_next = PH_IDLE;
                        end else if ((s & ST_ERR) != 0) begin
                            r[0] = '{ACT_DONE, 10'd0, 16'd0, 1'b0}; nres = 4'd1;
                            phase_next = PH_IDLE;
                        end else if ((s & ST_DRQ) != 0) begin
                            widx_next = '0;
                            r[0] = '{ACT_DATR, b, 16'd0, 1'b0}; nres = 4'd1;
                            phase_next = PH_DRAIN;
                        end else if (budget_reg == 0) begin
                            r[0] = '{ACT_DONE, 10'd0, 16'd0, 1'b1}; nres = 4'd1;
                            phase_next = PH_IDLE;
                        end else begin
                            budget_next = bm1;
                            if ((s & ST_BSY) == 0 && {1'b0, bm1} + 33'(QUIET_SAMPLE_LIMIT)
                                < {1'b0, timeout_reg}) begin
                                r[0] = '{ACT_DONE, 10'd0, 16'd0, 1'b1}; nres = 4'd1;
                                phase_next = PH_IDLE;
                            end else begin
                                r[0] = '{ACT_STAT, b + 10'd7, 16'd0, 1'b0}; nres = 4'd1;
                            end
                        end
                    PH_DRAIN:
                    begin
                        widx_next = widx_reg + 1'b1;
                        nres = 4'd1;
                        if (widx_next < SW) r[0] = '{ACT_DATR, b, 16'd0, 1'b0};
                        else begin
                            r[0] = '{ACT_DONE, 10'd0, 16'd0, 1'b0}; phase_next = PH_IDLE;
                        end
                    end
                    PH_IDLE_WAIT, PH_FLUSH_WAIT:
                    begin
                        nres = 4'd1;
                        if ((s & ST_BSY) != 0) begin
                            if (s == ST_FLOAT || budget_reg == 0) begin
                                r[0] = '{ACT_DONE, 10'd0, 16'd0, 1'b1}; phase_next = PH_IDLE;
                            end else begin
                                budget_next = bm1;
                                r[0] = '{ACT_STAT, b + 10'd7, 16'd0, 1'b0};
                            end
                        end else if ((s & (ST_ERR | ST_DF)) != 0) begin
                            r[0] = '{ACT_DONE, 10'd0, 16'd0, 1'b1}; phase_next = PH_IDLE;
                        end else if (phase_reg == PH_FLUSH_WAIT) begin
                            r[0] = '{ACT_DONE, 10'd0, 16'd0, 1'b0}; phase_next = PH_IDLE;
                        end else begin
                            budget_next = timeout_reg;
                            r[0] = '{ACT_STAT, b + 10'd7, 16'd0, 1'b0};
                            phase_next = PH_DRQ_WAIT;
                        end
                    end
                    PH_DRQ_WAIT:
                        if ((s & (ST_ERR | ST_DF)) != 0) begin
                            r[0] = '{ACT_DONE, 10'd0, 16'd0, 1'b1}; nres = 4'd1;
                            phase_next = PH_IDLE;
                        end else if ((s & ST_DRQ) != 0) begin
                            widx_next = '0;
                            if (cmd_reg == CMD_READ) begin
                                r[0] = '{ACT_DATR, b, 16'd0, 1'b0}; nres = 4'd1;
                                phase_next = PH_READ_DATA;
                            end else phase_next = PH_WRITE_DATA;
                        end else if (s == ST_FLOAT || budget_reg == 0) begin
                            r[0] = '{ACT_DONE, 10'd0, 16'd0, 1'b1}; nres = 4'd1;
                            phase_next = PH_IDLE;
                        end else begin
                            budget_next = bm1;
                            r[0] = '{ACT_STAT, b + 10'd7, 16'd0, 1'b0}; nres = 4'd1;
                        end
                    PH_READ_DATA:
                    begin
                        r[0] = '{ACT_HOST, 10'd0, v, 1'b0};
                        nres = 4'd2;
                        widx_next = widx_reg + 1'b1;
                        if (widx_next < SW) r[1] = '{ACT_DATR, b, 16'd0, 1'b0};
                        else begin
                            r[1] = '{ACT_DONE, 10'd0, 16'd0, 1'b0}; phase_next = PH_IDLE;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    assign s_axis_tready = ({1'b0, cnt_reg} + (in_v_reg ? {2'b0, nres} : 6'd0)) <= 6'd8;
    logic deq;
    assign deq = m_axis_tvalid && m_axis_tready;
    assign m_axis_tvalid = cnt_reg != 5'd0;
    assign m_axis_tdata = {2'd0, q_reg[rd_reg].outcome, q_reg[rd_reg].value,
                           q_reg[rd_reg].addr, q_reg[rd_reg].action};
    assign m_axis_tlast = q_last_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RES; i++) begin
            if (in_v_reg && 4'(i) < nres) begin
                q_reg[wr_reg + 4'(i)] <= r[i];
                q_last_reg[wr_reg + 4'(i)] <= (4'(i) == nres - 4'd1);
            end
        end
        if (s_axis_tvalid && s_axis_tready) in_reg <= s_axis_tdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            timeout_reg <= TIMEOUT_RESET;
            phase_reg <= PH_IDLE;
            budget_reg <= '0;
            settle_reg <= '0;
            widx_reg <= '0;
            cmd_reg <= '0;
            drv_reg <= '0;
            lba_reg <= '0;
            in_v_reg <= 1'b0;
            rd_reg <= '0;
            wr_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (cfg_valid) timeout_reg <= cfg_data;
            if (in_v_reg) begin
                phase_reg <= phase_next;
                budget_reg <= budget_next;
                settle_reg <= settle_next;
                widx_reg <= widx_next;
                cmd_reg <= cmd_next;
                drv_reg <= drv_next;
                lba_reg <= lba_next;
            end
            in_v_reg <= s_axis_tvalid && s_axis_tready;
            wr_reg <= wr_reg + (in_v_reg ? nres : 4'd0);
            if (deq) rd_reg <= rd_reg + 4'd1;
            cnt_reg <= cnt_reg + (in_v_reg ? {1'b0, nres} : 5'd0) - {4'd0, deq};
        end
    end

    `ASSERT_CLK(a_no_overflow, cnt_reg <= 5'd16, "result queue overflow")
    `ASSERT_CLK(a_burst_bound, !in_v_reg || nres <= 4'd8, "too many results")
    `ASSERT_CLK(a_room, in_v_reg |-> cnt_reg <= 5'd8, "no room for burst")
endmodule
